FILE: rtl/core/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern controller package
// Shared types, constants and helper functions for the LED blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpc_pkg;

  // Default number of LEDs driven by the controller.
  localparam int LBPC_NUM_LEDS = 3;

  // Field widths.
  localparam int LBPC_OP_W     = 2;
  localparam int LBPC_IDX_W    = 2;
  localparam int LBPC_MS_W     = 16;
  localparam int LBPC_COUNT_W  = 11;
  localparam int LBPC_LEVELS_W = 3;

  // Reciprocal of the 50 ms tick period, scaled by 2^22 and rounded up.
  localparam int LBPC_RECIP_W     = 17;
  localparam int LBPC_RECIP_SHIFT = 22;
  localparam logic [LBPC_RECIP_W-1:0] LBPC_RECIP_50 = 17'd83887;
  localparam int LBPC_PROD_W = LBPC_MS_W + LBPC_RECIP_W;

  localparam logic [LBPC_COUNT_W-1:0] LBPC_COUNT_MAX     = '1;
  localparam logic [LBPC_COUNT_W-1:0] LBPC_CONFIRM_TICKS = 11'd10;

  typedef enum logic [LBPC_OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_SET_MODE   = 2'd1,
    OP_CONFIRM    = 2'd2,
    OP_SET_ENABLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_LIT        = 2'd0,
    PH_DARK       = 2'd1,
    PH_ALWAYS_ON  = 2'd2,
    PH_ALWAYS_OFF = 2'd3
  } phase_t;

  // Command presented to every LED slice in the cycle it is executed.
  typedef struct packed {
    logic                    fire;
    op_t                     op;
    logic [LBPC_IDX_W-1:0]   led_index;
    logic [LBPC_COUNT_W-1:0] on_ticks;
    logic [LBPC_COUNT_W-1:0] off_ticks;
    logic                    flag;
  } cmd_t;

  // Truncating division of a millisecond value by 50, by reciprocal multiply.
  // The scaled error stays below one fiftieth over the whole 16-bit range.
  function automatic logic [LBPC_COUNT_W-1:0] div50(input logic [LBPC_MS_W-1:0] ms);
    logic [LBPC_PROD_W-1:0] prod;
    prod = LBPC_PROD_W'(ms) * LBPC_PROD_W'(LBPC_RECIP_50);
    return prod[LBPC_RECIP_SHIFT +: LBPC_COUNT_W];
  endfunction

  // Mode an LED takes from its lit and dark tick counts.
  function automatic phase_t mode_of(input logic [LBPC_COUNT_W-1:0] on_t,
                                     input logic [LBPC_COUNT_W-1:0] off_t);
    phase_t ph;
    if (on_t == '0) begin
      ph = PH_ALWAYS_OFF;
    end else if (off_t == '0) begin
      ph = PH_ALWAYS_ON;
    end else begin
      ph = PH_LIT;
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/led_blink_pattern_controller_top.sv
// ----------------------------------------------------------------------------
// LED blink pattern controller
// Drives NUM_LEDS LEDs from 50 ms ticks with enable, confirm flash and blink.
// Usage: each transfer on the item channel (item_valid, item_stall) carries
// one operation: a tick, a set mode, a confirm flash or a set enable. Every
// operation produces exactly one transfer on the result channel
// (result_valid, result_stall) carrying the pin levels of LEDs 0 to 2 after
// the operation has been applied.
// An item passes through the input register, where the millisecond times
// are converted to tick counts, and then through the LED slices, which
// write the result register. Throughput is one item per cycle while the
// receiver does not stall; the input register and the result register
// form a two-stage pipeline, so a new item is taken while an earlier
// result waits to be collected.
// When the receiver stalls, the result register holds its value, the LED
// state is not advanced, and item_stall rises once the input register is
// also occupied. Nothing is dropped or repeated.
// After reset every LED is enabled, in the always-off mode with its pin low,
// and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_pattern_controller_top #(
  parameter int NUM_LEDS = lbpc_pkg::LBPC_NUM_LEDS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic [lbpc_pkg::LBPC_OP_W-1:0]      operation,
  input  wire logic [lbpc_pkg::LBPC_IDX_W-1:0]     led_index,
  input  wire logic [lbpc_pkg::LBPC_MS_W-1:0]      on_ms,
  input  wire logic [lbpc_pkg::LBPC_MS_W-1:0]      off_ms,
  input  wire logic                                flag,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic [lbpc_pkg::LBPC_LEVELS_W-1:0]       led_levels
);

  // Input register: holds one decoded operation awaiting execution.
  logic                              stage_valid;
  lbpc_pkg::op_t                     stage_op;
  logic [lbpc_pkg::LBPC_IDX_W-1:0]   stage_index;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] stage_on_ticks;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] stage_off_ticks;
  logic                              stage_flag;

  logic                              result_free;
  logic                              execute;
  logic                              item_accept;
  lbpc_pkg::cmd_t                    cmd;
  logic [NUM_LEDS-1:0]               pins_next;
  logic [lbpc_pkg::LBPC_LEVELS_W-1:0] levels_next;

  // The result register can take a new value when it is empty or being read.
  assign result_free = !result_valid || !result_stall;
  assign execute     = stage_valid && result_free;
  assign item_stall  = stage_valid && !result_free;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_accept) begin
      stage_valid <= 1'b1;
    end else if (execute) begin
      stage_valid <= 1'b0;
    end
  end

  // The time conversion is done on the way in, so the execution stage only
  // sees tick counts.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      stage_op        <= lbpc_pkg::op_t'(operation);
      stage_index     <= led_index;
      stage_on_ticks  <= lbpc_pkg::div50(on_ms);
      stage_off_ticks <= lbpc_pkg::div50(off_ms);
      stage_flag      <= flag;
    end
  end

  assign cmd.fire      = execute;
  assign cmd.op        = stage_op;
  assign cmd.led_index = stage_index;
  assign cmd.on_ticks  = stage_on_ticks;
  assign cmd.off_ticks = stage_off_ticks;
  assign cmd.flag      = stage_flag;

  // One slice per LED; each decides for itself whether it is addressed.
  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lbpc_led #(
      .LED_ID(i)
    ) u_led (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .pin_next(pins_next[i])
    );
  end

  // Only the first three LEDs are reported; missing ones read as dark.
  for (genvar b = 0; b < lbpc_pkg::LBPC_LEVELS_W; b++) begin : g_level
    if (b < NUM_LEDS) begin : g_used
      assign levels_next[b] = pins_next[b];
    end else begin : g_unused
      assign levels_next[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (execute) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (execute) begin
      led_levels <= levels_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbpc_led.sv
// ----------------------------------------------------------------------------
// LED blink pattern controller, single LED slice
// Holds the state of one LED and applies each executed command to it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpc_led #(
  parameter int LED_ID = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lbpc_pkg::cmd_t cmd,
  output logic               pin_next
);

  localparam int CMP_W = 32;
  localparam logic [CMP_W-1:0] ID = CMP_W'(LED_ID);

  logic                              pin_level;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] tick_count;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] on_ticks;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] off_ticks;
  lbpc_pkg::phase_t                  phase;
  logic                              confirming;
  logic                              enabled;

  logic [lbpc_pkg::LBPC_COUNT_W-1:0] tick_count_next;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] on_ticks_next;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] off_ticks_next;
  lbpc_pkg::phase_t                  phase_next;
  logic                              confirming_next;
  logic                              enabled_next;

  logic                              sel;
  logic                              same;
  logic [lbpc_pkg::LBPC_COUNT_W-1:0] count_inc;
  lbpc_pkg::phase_t                  mode_stored;
  lbpc_pkg::phase_t                  mode_cmd;

  assign sel  = ({{(CMP_W-lbpc_pkg::LBPC_IDX_W){1'b0}}, cmd.led_index} == ID);
  assign same = (on_ticks == cmd.on_ticks) && (off_ticks == cmd.off_ticks) &&
                (confirming == cmd.flag);
  assign count_inc   = (tick_count == lbpc_pkg::LBPC_COUNT_MAX) ?
                       tick_count :
                       tick_count + {{(lbpc_pkg::LBPC_COUNT_W-1){1'b0}}, 1'b1};
  assign mode_stored = lbpc_pkg::mode_of(on_ticks, off_ticks);
  assign mode_cmd    = lbpc_pkg::mode_of(cmd.on_ticks, cmd.off_ticks);

  always_comb begin
    pin_next        = pin_level;
    tick_count_next = tick_count;
    on_ticks_next   = on_ticks;
    off_ticks_next  = off_ticks;
    phase_next      = phase;
    confirming_next = confirming;
    enabled_next    = enabled;
    if (cmd.fire) begin
      unique case (cmd.op)
        lbpc_pkg::OP_TICK: begin
          if (enabled) begin
            tick_count_next = count_inc;
            if (confirming) begin
              pin_next = ~pin_level;
              if (count_inc >= lbpc_pkg::LBPC_CONFIRM_TICKS) begin
                confirming_next = 1'b0;
                tick_count_next = '0;
                phase_next      = mode_stored;
                if (mode_stored == lbpc_pkg::PH_LIT) begin
                  pin_next = 1'b1;
                end
              end
            end else begin
              unique case (phase)
                lbpc_pkg::PH_LIT: begin
                  if (count_inc >= on_ticks) begin
                    tick_count_next = '0;
                    phase_next      = lbpc_pkg::PH_DARK;
                    pin_next        = 1'b0;
                  end
                end
                lbpc_pkg::PH_DARK: begin
                  if (count_inc >= off_ticks) begin
                    tick_count_next = '0;
                    phase_next      = lbpc_pkg::PH_LIT;
                    pin_next        = 1'b1;
                  end
                end
                lbpc_pkg::PH_ALWAYS_ON:  pin_next = 1'b1;
                lbpc_pkg::PH_ALWAYS_OFF: pin_next = 1'b0;
                default:                 pin_next = pin_level;
              endcase
            end
          end
        end
        lbpc_pkg::OP_SET_MODE: begin
          if (sel && !same) begin
            tick_count_next = '0;
            on_ticks_next   = cmd.on_ticks;
            off_ticks_next  = cmd.off_ticks;
            confirming_next = cmd.flag;
            phase_next      = mode_cmd;
            pin_next        = (mode_cmd == lbpc_pkg::PH_LIT);
          end
        end
        lbpc_pkg::OP_CONFIRM: begin
          if (sel) begin
            tick_count_next = '0;
            pin_next        = 1'b0;
            confirming_next = 1'b1;
          end
        end
        lbpc_pkg::OP_SET_ENABLE: begin
          if (sel) begin
            enabled_next = cmd.flag;
          end
        end
        default: enabled_next = enabled;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_level  <= 1'b0;
      tick_count <= '0;
      on_ticks   <= '0;
      off_ticks  <= '0;
      phase      <= lbpc_pkg::PH_ALWAYS_OFF;
      confirming <= 1'b0;
      enabled    <= 1'b1;
    end else begin
      pin_level  <= pin_next;
      tick_count <= tick_count_next;
      on_ticks   <= on_ticks_next;
      off_ticks  <= off_ticks_next;
      phase      <= phase_next;
      confirming <= confirming_next;
      enabled    <= enabled_next;
    end
  end

endmodule

`default_nettype wire

FILE: bench/led_blink_pattern_controller_top_tb.sv
// ----------------------------------------------------------------------------
// LED blink pattern controller testbench
// Sends ticks, mode changes, confirm flashes and enables with random gaps,
// stalls the result side at random, and checks every pin-level result
// against a cycle-free model of the LED slices kept in a scoreboard.
// ----------------------------------------------------------------------------
module led_blink_pattern_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbpc_pkg::*;

  localparam int LEDS = LBPC_NUM_LEDS;

  typedef logic [LBPC_COUNT_W-1:0]  count_t;
  typedef logic [LBPC_LEVELS_W-1:0] levels_t;

  // The scoreboard keeps its own copy of every LED's state. Each accepted
  // item is applied to that copy at once, and the pin levels that follow are
  // queued; results from the block are then matched in order.
  class led_pattern_tracker;
    bit      pin_on    [LEDS];
    count_t  ticks_run [LEDS];
    count_t  lit_ticks [LEDS];
    count_t  dark_ticks[LEDS];
    phase_t  led_phase [LEDS];
    bit      flashing  [LEDS];
    bit      active    [LEDS];

    levels_t expected_levels[$];

    int failures;
    int checked;
    int tick_items;
    int mode_items;
    int unchanged_modes;
    int confirm_items;
    int enable_items;
    int stray_items;

    function void clear();
      for (int i = 0; i < LEDS; i++) begin
        pin_on[i]     = 1'b0;
        ticks_run[i]  = '0;
        lit_ticks[i]  = '0;
        dark_ticks[i] = '0;
        led_phase[i]  = PH_ALWAYS_OFF;
        flashing[i]   = 1'b0;
        active[i]     = 1'b1;
      end
      expected_levels.delete();
    endfunction

    // Settle into the steady mode implied by the stored lit and dark times.
    function void take_mode(int i);
      if (lit_ticks[i] == '0) begin
        led_phase[i] = PH_ALWAYS_OFF;
      end else if (dark_ticks[i] == '0) begin
        led_phase[i] = PH_ALWAYS_ON;
      end else begin
        led_phase[i] = PH_LIT;
        pin_on[i]    = 1'b1;
      end
    endfunction

    function void advance_led(int i);
      if (!active[i]) return;
      if (ticks_run[i] != LBPC_COUNT_MAX) ticks_run[i] = ticks_run[i] + 1'b1;
      if (flashing[i]) begin
        pin_on[i] = ~pin_on[i];
        if (ticks_run[i] >= LBPC_CONFIRM_TICKS) begin
          flashing[i]  = 1'b0;
          ticks_run[i] = '0;
          take_mode(i);
        end
      end else begin
        case (led_phase[i])
          PH_LIT: begin
            if (ticks_run[i] >= lit_ticks[i]) begin
              ticks_run[i] = '0;
              led_phase[i] = PH_DARK;
              pin_on[i]    = 1'b0;
            end
          end
          PH_DARK: begin
            if (ticks_run[i] >= dark_ticks[i]) begin
              ticks_run[i] = '0;
              led_phase[i] = PH_LIT;
              pin_on[i]    = 1'b1;
            end
          end
          PH_ALWAYS_ON: begin
            pin_on[i] = 1'b1;
          end
          default: begin
            pin_on[i] = 1'b0;
          end
        endcase
      end
    endfunction

    function void note_item(op_t op, logic [LBPC_IDX_W-1:0] idx,
                            logic [LBPC_MS_W-1:0] on_ms, logic [LBPC_MS_W-1:0] off_ms,
                            logic flag);
      count_t  new_lit;
      count_t  new_dark;
      levels_t lv;
      if (op != OP_TICK && idx >= LEDS) begin
        stray_items++;
      end else begin
        case (op)
          OP_TICK: begin
            tick_items++;
            for (int i = 0; i < LEDS; i++) advance_led(i);
          end
          OP_SET_MODE: begin
            mode_items++;
            new_lit  = count_t'(on_ms / 16'd50);
            new_dark = count_t'(off_ms / 16'd50);
            if (new_lit == lit_ticks[idx] && new_dark == dark_ticks[idx] &&
                flashing[idx] == flag) begin
              unchanged_modes++;
            end else begin
              ticks_run[idx]  = '0;
              pin_on[idx]     = 1'b0;
              lit_ticks[idx]  = new_lit;
              dark_ticks[idx] = new_dark;
              flashing[idx]   = flag;
              take_mode(idx);
            end
          end
          OP_CONFIRM: begin
            confirm_items++;
            ticks_run[idx] = '0;
            pin_on[idx]    = 1'b0;
            flashing[idx]  = 1'b1;
          end
          default: begin
            enable_items++;
            active[idx] = flag;
          end
        endcase
      end
      lv = '0;
      for (int i = 0; i < LEDS && i < LBPC_LEVELS_W; i++) lv[i] = pin_on[i];
      expected_levels.push_back(lv);
    endfunction

    function void check_levels(levels_t actual);
      levels_t want;
      if (expected_levels.size() == 0) begin
        failures++;
        if (failures <= 20)
          $display("%0t ns: unexpected result, expected none, actual led_levels %03b",
                   $time, actual);
      end else begin
        want = expected_levels.pop_front();
        checked++;
        if (actual !== want) begin
          failures++;
          if (failures <= 20)
            $display("%0t ns: led_levels mismatch, expected %03b, actual %03b",
                     $time, want, actual);
        end
      end
    endfunction
  endclass

  // Every input starts at a known value; reset is held from time zero.
  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic [LBPC_OP_W-1:0]     operation    = '0;
  logic [LBPC_IDX_W-1:0]    led_index    = '0;
  logic [LBPC_MS_W-1:0]     on_ms        = '0;
  logic [LBPC_MS_W-1:0]     off_ms       = '0;
  logic                     flag         = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  levels_t                  led_levels;

  led_pattern_tracker tracker;

  // While calm_sender is set the item side sends back to back.
  bit calm_sender = 1'b0;

  // The last mode written to each index, so that a repeat of the same
  // settings can be sent on purpose to exercise the unchanged-settings case.
  logic [LBPC_MS_W-1:0] last_on  [4];
  logic [LBPC_MS_W-1:0] last_off [4];
  logic                 last_flag[4];

  led_blink_pattern_controller_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .led_index    (led_index),
    .on_ms        (on_ms),
    .off_ms       (off_ms),
    .flag         (flag),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .led_levels   (led_levels)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle cycles before the next item: mostly none, sometimes a few, and now
  // and then a long pause, so that gaps land on every stage of the pipeline.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_sender) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Millisecond values: mostly short times so that blinking is seen within a
  // handful of ticks, with the truncation edges and the full 16-bit range
  // mixed in.
  function automatic logic [LBPC_MS_W-1:0] pick_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LBPC_MS_W'($urandom_range(0, 400));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return 16'd49;
        2:       return 16'd50;
        default: return '1;
      endcase
    end
    return LBPC_MS_W'($urandom);
  endfunction

  // Present one item and hold it until the transfer takes place. Valid is
  // only lowered when a gap follows, so it never drops and rises in the same
  // step. Stall is sampled on the falling edge, where it is settled, and the
  // transfer is then taken on the following rising edge.
  task automatic send_item(input op_t op, input logic [LBPC_IDX_W-1:0] idx,
                           input logic [LBPC_MS_W-1:0] on_v,
                           input logic [LBPC_MS_W-1:0] off_v, input logic fl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    led_index  <= idx;
    on_ms      <= on_v;
    off_ms     <= off_v;
    flag       <= fl;
    @(negedge clk);
    while (item_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    tracker.note_item(op, idx, on_v, off_v, fl);
  endtask

  task automatic send_random_item();
    int                    pick;
    op_t                   op;
    logic [LBPC_IDX_W-1:0] idx;
    logic [LBPC_MS_W-1:0]  on_v;
    logic [LBPC_MS_W-1:0]  off_v;
    logic                  fl;
    pick  = $urandom_range(0, 99);
    idx   = ($urandom_range(0, 19) == 0) ? 2'd3 : LBPC_IDX_W'($urandom_range(0, LEDS - 1));
    // Fields an operation does not use still carry random values.
    on_v  = LBPC_MS_W'($urandom);
    off_v = LBPC_MS_W'($urandom);
    fl    = 1'($urandom_range(0, 1));
    if (pick < 55) begin
      op = OP_TICK;
    end else if (pick < 75) begin
      op = OP_SET_MODE;
      if ($urandom_range(0, 9) == 0) begin
        on_v  = last_on[idx];
        off_v = last_off[idx];
        fl    = last_flag[idx];
      end else begin
        on_v  = pick_ms();
        off_v = pick_ms();
        fl    = ($urandom_range(0, 4) == 0);
      end
      last_on[idx]   = on_v;
      last_off[idx]  = off_v;
      last_flag[idx] = fl;
    end else if (pick < 85) begin
      op = OP_CONFIRM;
    end else begin
      op = OP_SET_ENABLE;
      // Mostly enable, so that LEDs are not left frozen for long.
      fl = ($urandom_range(0, 3) != 0);
    end
    send_item(op, idx, on_v, off_v, fl);
  endtask

  // Result side: stall at random, with short and long stalls and now and
  // then a stretch with no stall at all. One assignment per rising edge.
  initial begin
    int   r;
    int   hold;
    logic level;
    wait (rst === 1'b0);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        level = 1'b0;
        hold  = $urandom_range(50, 150);
      end else if (r < 65) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else if (r < 95) begin
        level = 1'b1;
        hold  = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        hold  = $urandom_range(5, 20);
      end
      repeat (hold) begin
        @(posedge clk);
        result_stall <= level;
      end
    end
  end

  // Result monitor: a transfer is due at the next rising edge whenever valid
  // is high and stall is low on the falling edge before it.
  initial begin
    forever begin
      @(negedge clk);
      if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0)
        tracker.check_levels(led_levels);
    end
  end

  // Main sequence.
  initial begin
    int waited;
    tracker = new;
    tracker.clear();
    for (int i = 0; i < 4; i++) begin
      last_on[i]   = '0;
      last_off[i]  = '0;
      last_flag[i] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A tick straight after reset shows every LED dark, then
    // the longest blink times, a repeat of the same settings which must be
    // ignored, a zero lit time and a zero dark time, times just below one
    // tick that truncate to zero, a confirm request carried by a mode change,
    // a plain confirm, a mode change on a disabled LED, and a mode change, a
    // confirm and an enable aimed at an index beyond the last LED. Eleven ticks
    // then run the confirm flashes out and show the disabled LED frozen.
    send_item(OP_TICK,       2'd0, 16'd0,     16'd0,     1'b0);
    send_item(OP_SET_MODE,   2'd0, 16'hFFFF,  16'hFFFF,  1'b0);
    send_item(OP_SET_MODE,   2'd0, 16'hFFFF,  16'hFFFF,  1'b0);
    send_item(OP_SET_MODE,   2'd1, 16'd0,     16'd100,   1'b0);
    send_item(OP_SET_MODE,   2'd2, 16'd100,   16'd0,     1'b0);
    send_item(OP_TICK,       2'd0, 16'd0,     16'd0,     1'b0);
    send_item(OP_SET_MODE,   2'd1, 16'd49,    16'd49,    1'b0);
    send_item(OP_SET_MODE,   2'd0, 16'd50,    16'd50,    1'b1);
    send_item(OP_CONFIRM,    2'd2, 16'd0,     16'd0,     1'b0);
    send_item(OP_SET_ENABLE, 2'd1, 16'd0,     16'd0,     1'b0);
    send_item(OP_SET_MODE,   2'd1, 16'd150,   16'd100,   1'b0);
    send_item(OP_SET_MODE,   2'd3, 16'd100,   16'd100,   1'b1);
    send_item(OP_CONFIRM,    2'd3, 16'd0,     16'd0,     1'b0);
    send_item(OP_SET_ENABLE, 2'd3, 16'd0,     16'd0,     1'b0);
    repeat (11) send_item(OP_TICK, 2'd0, 16'd0, 16'd0, 1'b0);
    send_item(OP_SET_ENABLE, 2'd1, 16'd0,     16'd0,     1'b1);

    // Random part, in segments; roughly one segment in four runs without
    // any idling on the item side.
    for (int n = 0; n < 1500; n++) begin
      if (n % 150 == 0) calm_sender = ($urandom_range(0, 3) == 0);
      send_random_item();
    end
    calm_sender = 1'b0;

    // Closing run of ticks with one LED always on, one blinking fast and one
    // always off, all enabled, so that the steady LEDs hold their levels
    // while the blinking one keeps cycling.
    send_item(OP_SET_MODE,   2'd0, 16'd100, 16'd0,  1'b0);
    send_item(OP_SET_MODE,   2'd1, 16'd50,  16'd100, 1'b0);
    send_item(OP_SET_MODE,   2'd2, 16'd0,   16'd0,   1'b0);
    for (int i = 0; i < LEDS; i++)
      send_item(OP_SET_ENABLE, LBPC_IDX_W'(i), 16'd0, 16'd0, 1'b1);
    repeat (150) send_item(OP_TICK, 2'd0, LBPC_MS_W'($urandom), LBPC_MS_W'($urandom),
                           1'($urandom_range(0, 1)));

    item_valid <= 1'b0;

    // Drain the pipeline, then give it a few more cycles so that a surplus
    // result would still be caught.
    waited = 0;
    while (tracker.expected_levels.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (tracker.expected_levels.size() != 0) begin
      tracker.failures++;
      $display("%0t ns: %0d results never arrived", $time, tracker.expected_levels.size());
    end

    $display("Covered %0d ticks, %0d mode changes (%0d with unchanged settings), %0d confirms,",
             tracker.tick_items, tracker.mode_items, tracker.unchanged_modes,
             tracker.confirm_items);
    $display("%0d enable changes and %0d out-of-range items; %0d results compared.",
             tracker.enable_items, tracker.stray_items, tracker.checked);

    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net: a correct run needs a small fraction of this time.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
